// ===== src/ray_triangle_intersect_core_macros.svh =====
// Assertion macros for the checker file of the intersection core.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH

// Property that must hold at every sampled edge outside reset.
`define RTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rti_pkg.sv =====
// ---------------------------------------------------------------------------
// rti_pkg
// Widths, register indexes and reset values of the ray/triangle core.
// ---------------------------------------------------------------------------
package rti_pkg;

  // Coordinate width of the vertex and ray fields.
  localparam int CoordW = 32;
  // Edge and offset vectors: difference of two coordinates.
  localparam int EdgeW = CoordW + 1;
  // Cross product components, after the subtraction of two products.
  localparam int CrossW = 2 * EdgeW + 1;
  // Split point of a cross component for the dot product multipliers.
  localparam int SplitW = CoordW + 2;
  localparam int PlW = EdgeW + SplitW + 1;
  localparam int PhW = EdgeW + CrossW - SplitW;
  // Determinant and numerators, three summed products with margin.
  localparam int DotW = 3 * CoordW + 8;
  localparam int SumW = DotW + 1;
  localparam int FracBits = 16;
  localparam int QuoW = 31;
  localparam int RemW = DotW + QuoW + 1;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgDataW-1:0] EpsReset = 32'd28147498;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_EPS   = 3'd6
  } cfg_reg_e;

endpackage

// ===== src/ray_triangle_intersect_core.sv =====
// ---------------------------------------------------------------------------
// ray_triangle_intersect_core
// Pipelined Moller-Trumbore test of one configured ray against triangles.
// ---------------------------------------------------------------------------
// Usage: load the ray origin, direction and determinant threshold through
// the configuration channel (cfg_valid_i / cfg_ready_o, index and data)
// while the pipeline is empty; cfg_ready_o is always high. Then stream
// triangles in on the input channel: one transfer happens at every edge
// where in_valid_i is high and in_stall_o is low. Every triangle gives
// exactly one result transfer (hit_o, distance_o) on the output channel,
// in order, at an edge where out_valid_o is high and out_stall_i is low.
// The pipeline holds 8 arithmetic stages (edges, cross products, split dot
// products, sums, sign fold, range tests), 31 restoring divider stages
// that each settle one quotient bit, and the output register. One triangle
// can enter every cycle while in_stall_o is low.
// The whole pipeline advances together; when the output register holds a
// result that the receiver stalls, every stage freezes and in_stall_o
// rises, so nothing is dropped or repeated.
// Reset empties the pipeline and returns the registers to their reset
// values: origin and direction zero, threshold 28147498.
// ---------------------------------------------------------------------------
module ray_triangle_intersect_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rti_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [rti_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [rti_pkg::CoordW-1:0]     v0_x_i,
  input  logic signed [rti_pkg::CoordW-1:0]     v0_y_i,
  input  logic signed [rti_pkg::CoordW-1:0]     v0_z_i,
  input  logic signed [rti_pkg::CoordW-1:0]     v1_x_i,
  input  logic signed [rti_pkg::CoordW-1:0]     v1_y_i,
  input  logic signed [rti_pkg::CoordW-1:0]     v1_z_i,
  input  logic signed [rti_pkg::CoordW-1:0]     v2_x_i,
  input  logic signed [rti_pkg::CoordW-1:0]     v2_y_i,
  input  logic signed [rti_pkg::CoordW-1:0]     v2_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  hit_o,
  output logic [rti_pkg::QuoW-1:0]              distance_o
);

  localparam int CoordW = rti_pkg::CoordW;
  localparam int EdgeW  = rti_pkg::EdgeW;
  localparam int CrossW = rti_pkg::CrossW;
  localparam int SplitW = rti_pkg::SplitW;
  localparam int PlW    = rti_pkg::PlW;
  localparam int PhW    = rti_pkg::PhW;
  localparam int DotW   = rti_pkg::DotW;
  localparam int SumW   = rti_pkg::SumW;
  localparam int QuoW   = rti_pkg::QuoW;
  localparam int RemW   = rti_pkg::RemW;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes to an unused index are dropped.
  // ---------------------------------------------------------------------
  logic signed [CoordW-1:0]       org_q [3];
  logic signed [CoordW-1:0]       dir_q [3];
  logic [rti_pkg::CfgDataW-1:0]   eps_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        dir_q[i] <= '0;
      end
      eps_q <= rti_pkg::EpsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rti_pkg::cfg_reg_e'(cfg_index_i))
        rti_pkg::REG_ORG_X: org_q[0] <= CoordW'(cfg_data_i);
        rti_pkg::REG_ORG_Y: org_q[1] <= CoordW'(cfg_data_i);
        rti_pkg::REG_ORG_Z: org_q[2] <= CoordW'(cfg_data_i);
        rti_pkg::REG_DIR_X: dir_q[0] <= CoordW'(cfg_data_i);
        rti_pkg::REG_DIR_Y: dir_q[1] <= CoordW'(cfg_data_i);
        rti_pkg::REG_DIR_Z: dir_q[2] <= CoordW'(cfg_data_i);
        rti_pkg::REG_EPS:   eps_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline advance. All stages move together unless the output
  // register holds a result that the receiver stalls.
  // ---------------------------------------------------------------------
  logic out_valid_q;
  logic adv;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Ray direction at edge width, used by both cross and dot products.
  // The user must keep the configuration constant while items are in flight; the block does not enforce it.
  logic signed [EdgeW-1:0] dir_e [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_e[i] = EdgeW'(dir_q[i]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: edge vectors e1 = v1 - v0, e2 = v2 - v0 and s = origin - v0.
  // ---------------------------------------------------------------------
  logic signed [CoordW-1:0] v0 [3];
  logic signed [CoordW-1:0] v1 [3];
  logic signed [CoordW-1:0] v2 [3];
  logic signed [EdgeW-1:0]  e1_d [3];
  logic signed [EdgeW-1:0]  e2_d [3];
  logic signed [EdgeW-1:0]  s_d  [3];

  assign v0[0] = v0_x_i;
  assign v0[1] = v0_y_i;
  assign v0[2] = v0_z_i;
  assign v1[0] = v1_x_i;
  assign v1[1] = v1_y_i;
  assign v1[2] = v1_z_i;
  assign v2[0] = v2_x_i;
  assign v2[1] = v2_y_i;
  assign v2[2] = v2_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = EdgeW'(v1[i]) - EdgeW'(v0[i]);
      e2_d[i] = EdgeW'(v2[i]) - EdgeW'(v0[i]);
      s_d[i]  = EdgeW'(org_q[i]) - EdgeW'(v0[i]);
    end
  end

  logic                    s1_v_q;
  logic signed [EdgeW-1:0] s1_e1_q [3];
  logic signed [EdgeW-1:0] s1_e2_q [3];
  logic signed [EdgeW-1:0] s1_s_q  [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_e1_q <= e1_d;
      s1_e2_q <= e2_d;
      s1_s_q  <= s_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the twelve products of h = dir x e2 and q = s x e1.
  // Component i uses the other two axes j = i+1 and k = i+2 (mod 3).
  // ---------------------------------------------------------------------
  logic signed [2*EdgeW-1:0] hp_d [3][2];
  logic signed [2*EdgeW-1:0] qp_d [3][2];

  for (genvar i = 0; i < 3; i++) begin : g_cross_mul
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    assign hp_d[i][0] = dir_e[J] * s1_e2_q[K];
    assign hp_d[i][1] = dir_e[K] * s1_e2_q[J];
    assign qp_d[i][0] = s1_s_q[J] * s1_e1_q[K];
    assign qp_d[i][1] = s1_s_q[K] * s1_e1_q[J];
  end

  logic                      s2_v_q;
  logic signed [EdgeW-1:0]   s2_e1_q [3];
  logic signed [EdgeW-1:0]   s2_e2_q [3];
  logic signed [EdgeW-1:0]   s2_s_q  [3];
  logic signed [2*EdgeW-1:0] s2_hp_q [3][2];
  logic signed [2*EdgeW-1:0] s2_qp_q [3][2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_e1_q <= s1_e1_q;
      s2_e2_q <= s1_e2_q;
      s2_s_q  <= s1_s_q;
      s2_hp_q <= hp_d;
      s2_qp_q <= qp_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: cross product components by subtraction.
  // ---------------------------------------------------------------------
  logic signed [CrossW-1:0] h_d [3];
  logic signed [CrossW-1:0] q_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_d[i] = CrossW'(s2_hp_q[i][0]) - CrossW'(s2_hp_q[i][1]);
      q_d[i] = CrossW'(s2_qp_q[i][0]) - CrossW'(s2_qp_q[i][1]);
    end
  end

  logic                     s3_v_q;
  logic signed [EdgeW-1:0]  s3_e1_q [3];
  logic signed [EdgeW-1:0]  s3_e2_q [3];
  logic signed [EdgeW-1:0]  s3_s_q  [3];
  logic signed [CrossW-1:0] s3_h_q  [3];
  logic signed [CrossW-1:0] s3_q_q  [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_e1_q <= s2_e1_q;
      s3_e2_q <= s2_e2_q;
      s3_s_q  <= s2_s_q;
      s3_h_q  <= h_d;
      s3_q_q  <= q_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: dot product partial products. The four dot products are
  // the determinant a = e1.h, U = s.h, V = dir.q and T = e2.q. Each wide
  // cross component is split into an unsigned low part and a signed
  // high part so that no multiplier grows much past 33 x 35 bits.
  // ---------------------------------------------------------------------
  logic signed [EdgeW-1:0]  dx [4][3];
  logic signed [CrossW-1:0] dy [4][3];
  logic signed [PlW-1:0]    pl_d [4][3];
  logic signed [PhW-1:0]    ph_d [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx[0][i] = s3_e1_q[i];
      dy[0][i] = s3_h_q[i];
      dx[1][i] = s3_s_q[i];
      dy[1][i] = s3_h_q[i];
      dx[2][i] = dir_e[i];
      dy[2][i] = s3_q_q[i];
      dx[3][i] = s3_e2_q[i];
      dy[3][i] = s3_q_q[i];
    end
  end

  for (genvar d = 0; d < 4; d++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_term
      logic signed [SplitW:0]          y_lo;
      logic signed [CrossW-SplitW-1:0] y_hi;
      assign y_lo       = $signed({1'b0, dy[d][i][SplitW-1:0]});
      assign y_hi       = $signed(dy[d][i][CrossW-1:SplitW]);
      assign pl_d[d][i] = dx[d][i] * y_lo;
      assign ph_d[d][i] = dx[d][i] * y_hi;
    end
  end

  logic                  s4_v_q;
  logic signed [PlW-1:0] s4_pl_q [4][3];
  logic signed [PhW-1:0] s4_ph_q [4][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_pl_q <= pl_d;
      s4_ph_q <= ph_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: rebuild each product from its two partial products.
  // ---------------------------------------------------------------------
  logic signed [DotW-1:0] tm_d [4][3];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      for (int i = 0; i < 3; i++) begin
        tm_d[d][i] = (DotW'(s4_ph_q[d][i]) <<< SplitW) + DotW'(s4_pl_q[d][i]);
      end
    end
  end

  logic                   s5_v_q;
  logic signed [DotW-1:0] s5_tm_q [4][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_tm_q <= tm_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: sum the three terms of each dot product.
  // ---------------------------------------------------------------------
  logic signed [DotW-1:0] dt_d [4];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      dt_d[d] = s5_tm_q[d][0] + s5_tm_q[d][1] + s5_tm_q[d][2];
    end
  end

  logic                   s6_v_q;
  logic signed [DotW-1:0] s6_dt_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_dt_q <= dt_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: fold a negative determinant. All four values change sign so
  // that the range tests below only deal with a non-negative a.
  // ---------------------------------------------------------------------
  logic signed [DotW-1:0] fl_d [4];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      fl_d[d] = s6_dt_q[0][DotW-1] ? -s6_dt_q[d] : s6_dt_q[d];
    end
  end

  logic                   s7_v_q;
  logic signed [DotW-1:0] s7_fl_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_fl_q <= fl_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: parallel-ray, barycentric and distance sign tests, and the
  // divider set-up. The numerator is T shifted into Q15.16 units; when it
  // reaches a * 2^31 the quotient does not fit and the distance saturates.
  // ---------------------------------------------------------------------
  logic signed [DotW-1:0] a8, u8, v8, t8;
  logic signed [SumW-1:0] uv8;
  logic [RemW-1:0]        num8;
  logic [RemW-1:0]        lim8;
  logic                   miss8;
  logic                   sat8;

  always_comb begin
    a8    = s7_fl_q[0];
    u8    = s7_fl_q[1];
    v8    = s7_fl_q[2];
    t8    = s7_fl_q[3];
    uv8   = SumW'(u8) + SumW'(v8);
    num8  = RemW'(t8) << rti_pkg::FracBits;
    lim8  = RemW'(a8) << QuoW;
    miss8 = (a8 == '0)
         || (a8 < $signed(DotW'(eps_q)))
         || u8[DotW-1]
         || (a8 < u8)
         || v8[DotW-1]
         || (SumW'(a8) < uv8)
         || t8[DotW-1]
         || (t8 == '0);
    sat8  = num8 >= lim8;
  end

  // Divider pipeline. Entry 0 is the stage 8 register; entry k+1 holds
  // the partial remainder after quotient bit QuoW-1-k has been settled.
  logic              dv_v_q    [QuoW+1];
  logic              dv_miss_q [QuoW+1];
  logic              dv_sat_q  [QuoW+1];
  logic [DotW-1:0]   dv_a_q    [QuoW+1];
  logic [RemW-1:0]   dv_rem_q  [QuoW+1];
  logic [QuoW-1:0]   dv_quo_q  [QuoW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_miss_q[0] <= miss8;
      dv_sat_q[0]  <= sat8;
      dv_a_q[0]    <= DotW'(a8);
      dv_rem_q[0]  <= num8;
      dv_quo_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    localparam int Bit = QuoW - 1 - k;
    logic [RemW-1:0] dsub;
    logic            ge;

    assign dsub = RemW'(dv_a_q[k]) << Bit;
    assign ge   = dv_rem_q[k] >= dsub;

    // The bit settled here is still zero in the incoming quotient.
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_miss_q[k+1] <= dv_miss_q[k];
        dv_sat_q[k+1]  <= dv_sat_q[k];
        dv_a_q[k+1]    <= dv_a_q[k];
        dv_rem_q[k+1]  <= ge ? (dv_rem_q[k] - dsub) : dv_rem_q[k];
        dv_quo_q[k+1]  <= dv_quo_q[k] | (QuoW'(ge) << Bit);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register. A quotient of zero means t is below one Q15.16 step,
  // which counts as a miss.
  // ---------------------------------------------------------------------
  logic            hit_d;
  logic [QuoW-1:0] dist_d;
  logic            hit_q;
  logic [QuoW-1:0] dist_q;

  always_comb begin
    hit_d  = !dv_miss_q[QuoW] && (dv_sat_q[QuoW] || (dv_quo_q[QuoW] != '0));
    dist_d = '0;
    if (hit_d) begin
      dist_d = dv_sat_q[QuoW] ? {QuoW{1'b1}} : dv_quo_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  // Valid bits travel with the data and are the only reset pipeline state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      for (int k = 0; k <= QuoW; k++) begin
        dv_v_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      s6_v_q      <= s5_v_q;
      s7_v_q      <= s6_v_q;
      dv_v_q[0]   <= s7_v_q;
      for (int k = 0; k < QuoW; k++) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
      out_valid_q <= dv_v_q[QuoW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign distance_o  = dist_q;

endmodule

// ===== src/rti_checker.sv =====
// ---------------------------------------------------------------------------
// rti_checker
// Port-level checks of the ray/triangle intersection core.
// ---------------------------------------------------------------------------
`include "ray_triangle_intersect_core_macros.svh"

module rti_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             hit_o,
  input logic [rti_pkg::QuoW-1:0]         distance_o
);

  // A stalled result stays offered and unchanged.
  `RTI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(hit_o) && $stable(distance_o), "stalled result changed")

  // The input side only backs up when the output register is blocked.
  `RTI_ASSERT(a_stall_cause, !in_stall_o || (out_valid_o && out_stall_i), "input stall without output stall")

  // A miss always reports a zero distance.
  `RTI_ASSERT(a_miss_zero, !(out_valid_o && !hit_o) || (distance_o == '0), "miss with nonzero distance")

  // A hit always lies at least one distance step along the ray.
  `RTI_ASSERT(a_hit_nonzero, !(out_valid_o && hit_o) || (distance_o != '0), "hit with zero distance")

endmodule

bind ray_triangle_intersect_core rti_checker u_rti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o),
  .distance_o  (distance_o)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ray/triangle intersection core testbench
// Streams triangles against several configured rays, predicts hit flag and
// distance in wide exact arithmetic and checks every result in order, with
// random sender bursts, receiver stalls and long output hold-offs.
// ---------------------------------------------------------------------------

typedef logic signed [31:0] coord_t;
typedef coord_t tri_t [9];
typedef logic signed [191:0] wide_t;

typedef struct {
  logic        hit;
  logic [30:0] distance;
} hit_rec_t;

class intersect_scoreboard;
  logic [31:0] org[3];
  logic [31:0] dir[3];
  logic [31:0] eps;
  hit_rec_t    expected_q[$];
  int          errors;

  function new();
    foreach (org[i]) begin
      org[i] = '0;
      dir[i] = '0;
    end
    eps = rti_pkg::EpsReset;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      rti_pkg::REG_ORG_X: org[0] = data;
      rti_pkg::REG_ORG_Y: org[1] = data;
      rti_pkg::REG_ORG_Z: org[2] = data;
      rti_pkg::REG_DIR_X: dir[0] = data;
      rti_pkg::REG_DIR_Y: dir[1] = data;
      rti_pkg::REG_DIR_Z: dir[2] = data;
      rti_pkg::REG_EPS:   eps = data;
      default: ;
    endcase
  endfunction

  function void cross3(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function wide_t dot3(input wide_t a[3], input wide_t b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // Exact Moller-Trumbore: barycentric tests are done on numerators
  // against the determinant, only the distance is divided.
  function void note_triangle(tri_t t);
    wide_t    e1[3], e2[3], s[3], d[3], h[3], q[3];
    wide_t    det, num_u, num_v, num_t, n, quo;
    hit_rec_t r;
    r.hit = 1'b0;
    r.distance = '0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = wide_t'(t[3 + i]) - wide_t'(t[i]);
      e2[i] = wide_t'(t[6 + i]) - wide_t'(t[i]);
      s[i]  = wide_t'($signed(org[i])) - wide_t'(t[i]);
      d[i]  = wide_t'($signed(dir[i]));
    end
    cross3(d, e2, h);
    det = dot3(e1, h);
    num_u = dot3(s, h);
    cross3(s, e1, q);
    num_v = dot3(d, q);
    num_t = dot3(e2, q);
    if (det < 0) begin
      det = -det;
      num_u = -num_u;
      num_v = -num_v;
      num_t = -num_t;
    end
    if (det != 0 && det >= wide_t'({160'd0, eps}) && num_u >= 0 && num_u <= det &&
        num_v >= 0 && num_u + num_v <= det) begin
      n = num_t <<< 16;
      if (n > 0) begin
        quo = n / det;
        if (quo >= (wide_t'(1) <<< 31)) begin
          r.hit = 1'b1;
          r.distance = 31'h7FFF_FFFF;
        end else if (quo != 0) begin
          r.hit = 1'b1;
          r.distance = quo[30:0];
        end
      end
    end
    expected_q = {expected_q, r};
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic hit, logic [30:0] dist_in);
    hit_rec_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result hit=%0b distance=%0h", hit, dist_in));
    end else begin
      e = expected_q.pop_front();
      if (hit !== e.hit) report($sformatf("hit %0b, predicted %0b", hit, e.hit));
      if (dist_in !== e.distance) begin
        report($sformatf("distance %0h, predicted %0h", dist_in, e.distance));
      end
    end
  endtask
endclass

module tb;

  localparam int One = 65536;
  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 48;
  // Index beyond the register file; a write there must be ignored.
  localparam logic [rti_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rti_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [rti_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  coord_t v0_x_i = '0, v0_y_i = '0, v0_z_i = '0;
  coord_t v1_x_i = '0, v1_y_i = '0, v1_z_i = '0;
  coord_t v2_x_i = '0, v2_y_i = '0, v2_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic [rti_pkg::QuoW-1:0] distance_o;

  intersect_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_req = 0;

  ray_triangle_intersect_core uut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Every transfer is observed here, on values settled before the edge, so
  // the prediction never depends on the order of events within a step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o)
        sb.note_triangle('{v0_x_i, v0_y_i, v0_z_i, v1_x_i, v1_y_i, v1_z_i,
                           v2_x_i, v2_y_i, v2_z_i});
      if (out_valid_o && !out_stall_i) sb.check_result(hit_o, distance_o);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ray_triangle_intersect_core regression: fail");
      $finish;
    end
  end

  // Receiver stall pattern. A mode is drawn at random for each phase: no stall,
  // light, heavy and alternating. A hold-off request freezes the output for
  // a long stretch so that the pipeline fills and stalls its input.
  initial begin
    int mode;
    int phase_cnt;
    mode = 0;
    phase_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (150) @(posedge clk_i);
      end else begin
        if (phase_cnt == 0) mode = $urandom_range(0, 3);
        phase_cnt = (phase_cnt + 1) % 50;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // One write, followed by an idle edge so that back-to-back writes never
  // drive the valid twice in the same step.
  task automatic write_cfg(logic [rti_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_ray(int ox, int oy, int oz, int dx, int dy, int dz, logic [31:0] e);
    write_cfg(rti_pkg::REG_ORG_X, ox);
    write_cfg(rti_pkg::REG_ORG_Y, oy);
    write_cfg(rti_pkg::REG_ORG_Z, oz);
    write_cfg(rti_pkg::REG_DIR_X, dx);
    write_cfg(rti_pkg::REG_DIR_Y, dy);
    write_cfg(rti_pkg::REG_DIR_Z, dz);
    write_cfg(rti_pkg::REG_EPS, e);
  endtask

  // Wait until every predicted result has been checked, then let the
  // pipeline run dry before the registers may change. The first edge lets
  // the monitor note a transfer made at the current edge.
  task automatic drain();
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_tri(tri_t t);
    {v0_x_i, v0_y_i, v0_z_i} <= {t[0], t[1], t[2]};
    {v1_x_i, v1_y_i, v1_z_i} <= {t[3], t[4], t[5]};
    {v2_x_i, v2_y_i, v2_z_i} <= {t[6], t[7], t[8]};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic int jitter(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Triangle in a plane across the ray, mostly placed in front of the origin and
  // spread around the ray's axis so that hits and misses are both common.
  function automatic tri_t aimed_tri();
    tri_t t;
    int depth;
    depth = $urandom_range(0, 200 * One);
    if ($signed(sb.dir[2]) < 0) depth = -depth;
    if ($urandom_range(0, 9) == 0) depth = -depth;
    for (int k = 0; k < 3; k++) begin
      t[3 * k]     = $signed(sb.org[0]) + jitter(4 * One);
      t[3 * k + 1] = $signed(sb.org[1]) + jitter(4 * One);
      t[3 * k + 2] = $signed(sb.org[2]) + depth + jitter(One);
    end
    return t;
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    int kind;
    kind = $urandom_range(0, 9);
    t = aimed_tri();
    if (kind < 7) return t;
    if (kind == 7) begin
      foreach (t[i]) t[i] = $urandom;
    end else if (kind == 8) begin
      t[3 * $urandom_range(0, 2) + $urandom_range(0, 2)] = $urandom;
    end else begin
      // Degenerate triangle: two vertices coincide.
      t[3] = t[0];
      t[4] = t[1];
      t[5] = t[2];
    end
    return t;
  endfunction

  // Sends triangles in bursts of random length separated by random gaps.
  task automatic run_random(int count, bit with_hold);
    int burst_left;
    burst_left = $urandom_range(1, 20);
    for (int k = 0; k < count; k++) begin
      if (with_hold && k == count / 3) hold_req = 1;
      send_tri(random_tri());
      burst_left--;
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic run_list(tri_t list[$]);
    foreach (list[i]) send_tri(list[i]);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    tri_t list[$];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset ray has a zero direction, so every triangle is a miss.
    list = '{'{-One, -One, 5 * One, 3 * One, -One, 5 * One, -One, 3 * One, 5 * One},
             '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1,
               32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000}};
    run_list(list);
    drain();

    // Ray from the origin along +z, no parallel threshold.
    load_ray(0, 0, 0, 0, 0, One, 0);
    write_cfg(RegUnused, 32'hFFFF_FFFF);
    list = '{
      // Clean hit, and the same triangle with reversed winding.
      '{-One, -One, 5 * One, 3 * One, -One, 5 * One, -One, 3 * One, 5 * One},
      '{-One, -One, 5 * One, -One, 3 * One, 5 * One, 3 * One, -One, 5 * One},
      // Ray passes exactly through an edge (u + v equal to one).
      '{-One, -One, 5 * One, One, -One, 5 * One, -One, One, 5 * One},
      // Ray exactly on a vertex (u and v zero).
      '{0, 0, 2 * One, 2 * One, 0, 2 * One, 0, 2 * One, 2 * One},
      // u below zero, u above one, v below zero, u and v both below zero.
      '{One, -One, 5 * One, 4 * One, -One, 5 * One, One, 3 * One, 5 * One},
      '{-4 * One, -One, 5 * One, -2 * One, -One, 5 * One, -4 * One, 3 * One, 5 * One},
      '{-One, One, 5 * One, 3 * One, One, 5 * One, -One, 4 * One, 5 * One},
      '{One, One, 5 * One, 3 * One, One, 5 * One, One, 3 * One, 5 * One},
      // Behind the origin, through the origin, one distance step away.
      '{-One, -One, -5 * One, 3 * One, -One, -5 * One, -One, 3 * One, -5 * One},
      '{-One, -One, 0, 3 * One, -One, 0, -One, 3 * One, 0},
      '{-One, -One, 1, 3 * One, -One, 1, -One, 3 * One, 1},
      // Plane parallel to the ray: zero determinant.
      '{2 * One, -One, 0, 2 * One, One, 0, 2 * One, 0, One},
      // Plane slightly tilted off z = 0: hit point below one distance step.
      '{-One, -One, 0, One, -One, 1, -One, One, 0},
      // Extreme coordinates.
      '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}};
    run_list(list);
    drain();

    // Direction of one step: the distance saturates.
    load_ray(0, 0, 0, 0, 0, 1, 0);
    list = '{'{-One, -One, 100 * One, 3 * One, -One, 100 * One, -One, 3 * One, 100 * One},
             '{-One, -One, 32'h7FFF_FFFF, 3 * One, -One, 32'h7FFF_FFFF,
               -One, 3 * One, 32'h7FFF_FFFF}};
    run_list(list);
    drain();

    // Largest threshold, still below the determinant of an ordinary triangle.
    write_cfg(rti_pkg::REG_EPS, 32'hFFFF_FFFF);
    list = '{'{-One, -One, 5 * One, 3 * One, -One, 5 * One, -One, 3 * One, 5 * One}};
    run_list(list);
    drain();

    // Random phases over several rays, the extremes among them.
    load_ray(0, 0, 0, 0, 0, One, rti_pkg::EpsReset);
    run_random(180, 1'b1);
    drain();
    load_ray(3 * One / 2, -2 * One, -100 * One, One / 4, -One / 2, -3 * One, 0);
    run_random(180, 1'b0);
    drain();
    load_ray(-7 * One, 5 * One, 10 * One, -One / 8, One / 16, One / 2, 32'h0010_0000);
    run_random(180, 1'b0);
    drain();
    load_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h8000_0000, 0);
    run_random(150, 1'b0);
    drain();
    load_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(100, 1'b0);
    drain();
    load_ray(0, 0, 20 * One, 0, 0, -1, 32'hFFFF_FFFF);
    run_random(80, 1'b0);
    drain();
    load_ray(One, One, 0, 0, 0, 7 * One, 1);
    run_random(180, 1'b1);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ray_triangle_intersect_core regression: pass");
    end else begin
      $display("ray_triangle_intersect_core regression: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/rti_pkg.sv
src/ray_triangle_intersect_core.sv
src/rti_checker.sv
tb/tb.sv
